/* src/sosl_pkg.sv */
// ----------------------------------------------------------------------------
// sosl_pkg - shared types for the second-order state-space low-pass filter
// Payload structs, microcode control word, step codes, fixed-point constants
// and the rounding / saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package sosl_pkg;

   // Data and coefficient formats: Q12.20 data, Q4.28 coefficients
   localparam int DATA_W    = 32;
   localparam int COEF_W    = 32;
   localparam int COEF_FRAC = COEF_W - 4;
   localparam int INV_W     = 31;
   localparam int INV_FRAC  = 16;

   // Shared multiplier: one spare bit so that coefficients, data and the
   // rate difference all fit as signed operands
   localparam int OP_W   = DATA_W + 1;
   localparam int PROD_W = 2 * OP_W;
   localparam int ACC_W  = PROD_W;

   // Angle constants in Q12.20
   localparam int PI_Q     = 3294199;
   localparam int TWO_PI_Q = 6588398;

   // Position wrap: bias the position by 2pi * 2^(MOD_STEPS-1), then
   // strip multiples of 2pi one shifted subtract at a time
   localparam int MOD_STEPS = 10;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);
   localparam int MOD_W     = DATA_W + 2;
   localparam logic [MOD_W-1:0] MOD_BIAS = MOD_W'(TWO_PI_Q) << (MOD_STEPS - 1);

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_A11   = 3'd0,
      REG_A12   = 3'd1,
      REG_A21   = 3'd2,
      REG_A22   = 3'd3,
      REG_B1    = 3'd4,
      REG_B2    = 3'd5,
      REG_ANGLE = 3'd6,
      REG_INV   = 3'd7
   } reg_index_type;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< COEF_FRAC;

   typedef struct packed {
      logic                     cmd;
      logic signed [DATA_W-1:0] sample;
      logic signed [DATA_W-1:0] rate_preset;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] rate;
      logic signed [DATA_W-1:0] accel;
      logic                     wrapped;
   } rsp_payload_type;

   // Microprogram steps
   typedef enum logic [3:0] {
      ST_IDLE    = 4'd0,
      ST_PREP    = 4'd1,
      ST_M_A11   = 4'd2,
      ST_M_A12   = 4'd3,
      ST_M_B1    = 4'd4,
      ST_M_A21   = 4'd5,
      ST_M_A22   = 4'd6,
      ST_M_B2    = 4'd7,
      ST_ACC_END = 4'd8,
      ST_UPDATE  = 4'd9,
      ST_M_ACCEL = 4'd10,
      ST_RESP    = 4'd11,
      ST_PRESET  = 4'd12,
      ST_MOD     = 4'd13,
      ST_MODPOS  = 4'd14
   } step_type;

   typedef enum logic [2:0] {
      MA_A11, MA_A12, MA_A21, MA_A22, MA_B1, MA_B2, MA_DIFF
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_POS, MB_RATE, MB_U, MB_INV
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      COND_NEXT, COND_JUMP, COND_CMD, COND_WRAP, COND_LOOP
   } cond_type;

   // One control word per step
   typedef struct packed {
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      acc_op_type acc_op;
      logic       take_req;
      logic       load_u;
      logic       np_wr;
      logic       state_wr;
      logic       preset_wr;
      logic       mod_step;
      logic       mod_pos_wr;
      logic       rsp_wr;
      cond_type   cond;
      step_type   target;
   } ctrl_type;

   // Status fed back to the sequencer
   typedef struct packed {
      logic req_valid;
      logic rsp_busy;
      logic cmd;
      logic wrap;
      logic loop_more;
   } stat_type;

   // Control store
   function automatic ctrl_type ucode(step_type s);
      ctrl_type c;
      c = '{mul_a: MA_A11, mul_b: MB_POS, acc_op: ACC_HOLD, take_req: 1'b0,
            load_u: 1'b0, np_wr: 1'b0, state_wr: 1'b0, preset_wr: 1'b0,
            mod_step: 1'b0, mod_pos_wr: 1'b0, rsp_wr: 1'b0,
            cond: COND_NEXT, target: ST_IDLE};
      case (s)
         ST_IDLE: begin
            c.take_req = 1'b1;
         end
         ST_PREP: begin
            c.load_u = 1'b1;
            c.cond   = COND_CMD;
            c.target = ST_PRESET;
         end
         ST_M_A11: begin
            c.mul_a = MA_A11;
            c.mul_b = MB_POS;
         end
         ST_M_A12: begin
            c.mul_a  = MA_A12;
            c.mul_b  = MB_RATE;
            c.acc_op = ACC_LOAD;
         end
         ST_M_B1: begin
            c.mul_a  = MA_B1;
            c.mul_b  = MB_U;
            c.acc_op = ACC_ADD;
         end
         ST_M_A21: begin
            c.mul_a  = MA_A21;
            c.mul_b  = MB_POS;
            c.acc_op = ACC_ADD;
         end
         ST_M_A22: begin
            c.mul_a  = MA_A22;
            c.mul_b  = MB_RATE;
            c.acc_op = ACC_LOAD;
            c.np_wr  = 1'b1;
         end
         ST_M_B2: begin
            c.mul_a  = MA_B2;
            c.mul_b  = MB_U;
            c.acc_op = ACC_ADD;
         end
         ST_ACC_END: begin
            c.acc_op = ACC_ADD;
         end
         ST_UPDATE: begin
            c.state_wr = 1'b1;
            c.cond     = COND_WRAP;
            c.target   = ST_MOD;
         end
         ST_M_ACCEL: begin
            c.mul_a = MA_DIFF;
            c.mul_b = MB_INV;
         end
         ST_RESP: begin
            c.mul_a  = MA_DIFF;
            c.mul_b  = MB_INV;
            c.rsp_wr = 1'b1;
            c.cond   = COND_JUMP;
            c.target = ST_IDLE;
         end
         ST_PRESET: begin
            c.preset_wr = 1'b1;
            c.cond      = COND_JUMP;
            c.target    = ST_M_ACCEL;
         end
         ST_MOD: begin
            c.mod_step = 1'b1;
            c.cond     = COND_LOOP;
            c.target   = ST_MOD;
         end
         ST_MODPOS: begin
            c.mod_pos_wr = 1'b1;
            c.cond       = COND_JUMP;
            c.target     = ST_M_ACCEL;
         end
         default: begin
            c.cond   = COND_JUMP;
            c.target = ST_IDLE;
         end
      endcase
      return c;
   endfunction

   // Round half up from Q18.48 to Q12.20 and saturate
   function automatic logic signed [DATA_W-1:0] round_sat_acc(
      logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0]           t;
      logic signed [ACC_W-COEF_FRAC-1:0] s;
      logic signed [DATA_W-1:0]          r;
      t = v + (ACC_W'(1) <<< (COEF_FRAC - 1));
      s = t[ACC_W-1:COEF_FRAC];
      if ((&s[ACC_W-COEF_FRAC-1:DATA_W-1]) || !(|s[ACC_W-COEF_FRAC-1:DATA_W-1])) begin
         r = s[DATA_W-1:0];
      end else begin
         r = s[ACC_W-COEF_FRAC-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Round half up from Q30.36 to Q12.20 and saturate
   function automatic logic signed [DATA_W-1:0] round_sat_accel(
      logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0]          t;
      logic signed [PROD_W-INV_FRAC-1:0] s;
      logic signed [DATA_W-1:0]          r;
      t = v + (PROD_W'(1) <<< (INV_FRAC - 1));
      s = t[PROD_W-1:INV_FRAC];
      if ((&s[PROD_W-INV_FRAC-1:DATA_W-1]) || !(|s[PROD_W-INV_FRAC-1:DATA_W-1])) begin
         r = s[DATA_W-1:0];
      end else begin
         r = s[PROD_W-INV_FRAC-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   // 2pi scaled by 2^k for the wrap reduction
   function automatic logic [MOD_W-1:0] mod_sub(logic [MOD_CNT_W-1:0] k);
      return MOD_W'(TWO_PI_Q) << k;
   endfunction

endpackage

/* src/sosl_seq.sv */
// ----------------------------------------------------------------------------
// sosl_seq - microprogram sequencer
// Step counter over the control store; holds on handshake waits and takes
// conditional jumps from datapath status.
// ----------------------------------------------------------------------------
module sosl_seq
   import sosl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl,
   output step_type step
);

   step_type step_ff;
   step_type step_in;
   logic     hold;
   logic     taken;

   // Decode current step and pick the next one
   always_comb begin
      ctrl  = ucode(step_ff);
      hold  = (ctrl.take_req && !stat.req_valid) || (ctrl.rsp_wr && stat.rsp_busy);
      case (ctrl.cond)
         COND_NEXT: taken = 1'b0;
         COND_JUMP: taken = 1'b1;
         COND_CMD:  taken = stat.cmd;
         COND_WRAP: taken = stat.wrap;
         COND_LOOP: taken = stat.loop_more;
         default:   taken = 1'b0;
      endcase
      if (hold) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_type'(4'(step_ff) + 4'd1);
      end
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

/* src/second_order_state_space_lowpass.sv */
// Beats: a new beat is taken only in the idle step, once the previous one has
// been answered; a held response stalls the return to idle.
// Filtering makes six passes through the single shared multiplier plus the
// accel one; a wrap adds the reduction loop and a preset skips the filter.
// Reset: synchronous; coefficients return to A = identity, B = 0, state clears.
// ----------------------------------------------------------------------------
// second_order_state_space_lowpass - microcoded fixed-point state-space filter
// Updates [position, rate] = A*x + B*u with one shared multiplier, optional
// 2pi unwrap of the input and wrap of the position, and reports accel.
// ----------------------------------------------------------------------------
module second_order_state_space_lowpass
   import sosl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  reg_index_type   csr_index,
   input  logic [31:0]     csr_wdata
);

   ctrl_type ctrl;
   stat_type stat;
   step_type step;

   // Configuration registers
   logic signed [COEF_W-1:0] a11_ff, a12_ff, a21_ff, a22_ff, b1_ff, b2_ff;
   logic                     angle_ff;
   logic [INV_W-1:0]         inv_ff;

   // Filter state
   logic signed [DATA_W-1:0] pos_ff, pos_in;
   logic signed [DATA_W-1:0] rate_ff, rate_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;

   // Working registers
   logic                     cmd_ff;
   logic signed [DATA_W-1:0] sample_ff;
   logic signed [DATA_W-1:0] preset_ff;
   logic signed [DATA_W-1:0] u_ff, u_in;
   logic                     wrap_ff, wrap_in;
   logic signed [DATA_W-1:0] np_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [MOD_W-1:0]         mod_r_ff, mod_r_in;
   logic [MOD_CNT_W-1:0]     cnt_ff, cnt_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff;

   logic                     req_fire;
   logic                     rsp_busy;
   logic                     rsp_load;
   logic signed [OP_W-1:0]   op_a, op_b;
   logic signed [DATA_W:0]   diff;
   logic signed [DATA_W+1:0] u_wide;
   logic                     u_shift;
   logic [MOD_W-1:0]         sub;

   sosl_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl),
      .step  (step)
   );

   assign req_fire  = req_valid && ctrl.take_req;
   assign req_stall = !ctrl.take_req;
   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_load  = ctrl.rsp_wr && !rsp_busy;

   assign stat = '{req_valid: req_valid, rsp_busy: rsp_busy, cmd: cmd_ff,
                   wrap: wrap_ff, loop_more: (cnt_ff != '0)};

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a11_ff   <= COEF_ONE;
         a12_ff   <= '0;
         a21_ff   <= '0;
         a22_ff   <= COEF_ONE;
         b1_ff    <= '0;
         b2_ff    <= '0;
         angle_ff <= 1'b0;
         inv_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_A11:   a11_ff   <= csr_wdata[COEF_W-1:0];
            REG_A12:   a12_ff   <= csr_wdata[COEF_W-1:0];
            REG_A21:   a21_ff   <= csr_wdata[COEF_W-1:0];
            REG_A22:   a22_ff   <= csr_wdata[COEF_W-1:0];
            REG_B1:    b1_ff    <= csr_wdata[COEF_W-1:0];
            REG_B2:    b2_ff    <= csr_wdata[COEF_W-1:0];
            REG_ANGLE: angle_ff <= csr_wdata[0];
            REG_INV:   inv_ff   <= csr_wdata[INV_W-1:0];
            default:   ;
         endcase
      end
   end

   // Unwrap the sample toward the current position in angle mode, and saturate
   always_comb begin
      diff    = (DATA_W+1)'(sample_ff) - (DATA_W+1)'(pos_ff);
      u_wide  = (DATA_W+2)'(sample_ff);
      u_shift = 1'b0;
      if (angle_ff) begin
         if (diff > (DATA_W+1)'(PI_Q)) begin
            u_wide  = (DATA_W+2)'(sample_ff) - (DATA_W+2)'(TWO_PI_Q);
            u_shift = 1'b1;
         end else if (diff < -((DATA_W+1)'(PI_Q))) begin
            u_wide  = (DATA_W+2)'(sample_ff) + (DATA_W+2)'(TWO_PI_Q);
            u_shift = 1'b1;
         end
      end
      if ((&u_wide[DATA_W+1:DATA_W-1]) || !(|u_wide[DATA_W+1:DATA_W-1])) begin
         u_in = u_wide[DATA_W-1:0];
      end else begin
         u_in = u_wide[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      wrap_in = u_shift && !cmd_ff;
   end

   // Select multiplier operands
   always_comb begin
      case (ctrl.mul_a)
         MA_A11:  op_a = OP_W'(a11_ff);
         MA_A12:  op_a = OP_W'(a12_ff);
         MA_A21:  op_a = OP_W'(a21_ff);
         MA_A22:  op_a = OP_W'(a22_ff);
         MA_B1:   op_a = OP_W'(b1_ff);
         MA_B2:   op_a = OP_W'(b2_ff);
         MA_DIFF: op_a = OP_W'(rate_ff) - OP_W'(prev_ff);
         default: op_a = '0;
      endcase
      case (ctrl.mul_b)
         MB_POS:  op_b = OP_W'(pos_ff);
         MB_RATE: op_b = OP_W'(rate_ff);
         MB_U:    op_b = OP_W'(u_ff);
         MB_INV:  op_b = OP_W'({1'b0, inv_ff});
         default: op_b = '0;
      endcase
      prod_in = op_a * op_b;
   end

   // Accumulate products
   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD: acc_in = prod_ff;
         ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   // Reduce the wrapped position: bias, then one shifted subtract a step
   always_comb begin
      sub      = mod_sub(cnt_ff);
      mod_r_in = mod_r_ff;
      cnt_in   = cnt_ff;
      if (ctrl.state_wr) begin
         mod_r_in = MOD_W'(np_ff) + MOD_BIAS;
         cnt_in   = MOD_CNT_W'(MOD_STEPS - 1);
      end else if (ctrl.mod_step) begin
         if (mod_r_ff >= sub) begin
            mod_r_in = mod_r_ff - sub;
         end
         cnt_in = cnt_ff - MOD_CNT_W'(1);
      end
   end

   // Next filter state
   always_comb begin
      pos_in  = pos_ff;
      rate_in = rate_ff;
      prev_in = prev_ff;
      if (ctrl.state_wr) begin
         pos_in  = np_ff;
         rate_in = round_sat_acc(acc_ff);
         prev_in = rate_ff;
      end else if (ctrl.preset_wr) begin
         pos_in  = sample_ff;
         rate_in = preset_ff;
      end else if (ctrl.mod_pos_wr) begin
         pos_in  = mod_r_ff[DATA_W-1:0];
      end
   end

   // Hold or drop the response beat
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rate_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rate_ff      <= rate_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      mod_r_ff <= mod_r_in;
      cnt_ff   <= cnt_in;
      if (req_fire) begin
         cmd_ff    <= req_data.cmd;
         sample_ff <= req_data.sample;
         preset_ff <= req_data.rate_preset;
      end
      if (ctrl.load_u) begin
         u_ff    <= u_in;
         wrap_ff <= wrap_in;
      end
      if (ctrl.np_wr) begin
         np_ff <= round_sat_acc(acc_ff);
      end
      if (rsp_load) begin
         rsp_data_ff.position <= pos_ff;
         rsp_data_ff.rate     <= rate_ff;
         rsp_data_ff.accel    <= round_sat_accel(prod_ff);
         rsp_data_ff.wrapped  <= wrap_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new response appears only from the response step
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step == ST_RESP))
      else $error("response raised outside the response step");

   // Wrap reduction leaves the position inside one turn
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      (step == ST_MODPOS) |-> (mod_r_ff < MOD_W'(TWO_PI_Q)))
      else $error("wrapped position not reduced below 2pi");

   // Wrap only in angle mode and never on a preset beat
   a_wrap_mode: assert property (@(posedge clock) disable iff (reset)
      (step == ST_RESP && wrap_ff) |-> (angle_ff && !cmd_ff))
      else $error("wrap flagged without angle mode or on preset");

   // Reduction loop entered from the update step only
   a_mod_entry: assert property (@(posedge clock) disable iff (reset)
      (step == ST_MOD && $past(step) != ST_MOD) |-> $past(step == ST_UPDATE))
      else $error("reduction loop entered out of sequence");

endmodule
